@@ hw/rtl/spa_pkg.sv @@
// Shared types and constants for the paged-register SPI master.
// Used by spi_paged_register_access_core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Width of the phase tick counter.
  localparam int TickW   = 10;
  localparam int MaxTick = (1 << TickW) - 1;

  localparam int CfgW       = 10;
  localparam int FrameBits  = 16;
  localparam int AddrBits   = 8;

  // Input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_CS_SETUP    = 2'd1;
  localparam logic [1:0] CFG_FRAME_GAP   = 2'd2;

  localparam logic [CfgW-1:0] HALF_PERIOD_RST = 10'd10;
  localparam logic [CfgW-1:0] CS_SETUP_RST    = 10'd5;
  localparam logic [CfgW-1:0] FRAME_GAP_RST   = 10'd10;

  // Sequencer phases: setup / clock high / clock low / gap, for each frame
  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_S1   = 9'b000000010,
    PH_H1   = 9'b000000100,
    PH_L1   = 9'b000001000,
    PH_G1   = 9'b000010000,
    PH_S2   = 9'b000100000,
    PH_H2   = 9'b001000000,
    PH_L2   = 9'b010000000,
    PH_G2   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       rejected;
  } res_t;

  // Zero counts as one tick; values beyond the counter are clamped.
  function automatic logic [TickW-1:0] dur_f(input logic [CfgW-1:0] r);
    logic [CfgW-1:0] d;
    d = (r == '0) ? CfgW'(1) : r;
    if (int'(d) > MaxTick) begin
      return TickW'(MaxTick);
    end
    return TickW'(d);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spi_paged_register_access_core.sv @@
// Paged-register SPI master: tick-stepped bit-bang sequencer with a
// registered result stage and a one-entry skid buffer.
// Each result is registered, in the skid register on a stall. Throughput: one
// item per clock while in_stall is low; the state update for an item is a single
// pass of logic from the sequencer registers to the result register.
// in_stall rises only when both the result and skid registers are full.
// Reset (rst_n low, synchronous): idle, config registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module spi_paged_register_access_core (
  input  wire        clk,
  input  wire        rst_n,
  // item input
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_opcode,
  input  wire  [7:0] in_page,
  input  wire  [6:0] in_reg_addr,
  input  wire  [7:0] in_wr_value,
  input  wire        in_miso,
  // result output
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_cs_n,
  output logic       out_sclk,
  output logic       out_mosi,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rd_byte,
  output logic       out_rejected,
  // configuration writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [9:0] cfg_wdata
);

  // ---------------- configuration ----------------
  logic [spa_pkg::CfgW-1:0] half_period_r, cs_setup_r, frame_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= spa_pkg::HALF_PERIOD_RST;
      cs_setup_r    <= spa_pkg::CS_SETUP_RST;
      frame_gap_r   <= spa_pkg::FRAME_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spa_pkg::CFG_HALF_PERIOD: half_period_r <= cfg_wdata;
        spa_pkg::CFG_CS_SETUP:    cs_setup_r    <= cfg_wdata;
        spa_pkg::CFG_FRAME_GAP:   frame_gap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  spa_pkg::phase_t           phase_r, phase_nxt;
  logic [4:0]                bit_cnt_r, bit_cnt_nxt;
  logic [spa_pkg::TickW-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [15:0]               tx_shift_r, tx_shift_nxt;
  logic [15:0]               second_word_r, second_word_nxt;
  logic                      is_read_r, is_read_nxt;
  logic [7:0]                rx_shift_r, rx_shift_nxt;
  logic [7:0]                last_read_r, last_read_nxt;
  logic                      mosi_lvl_r, mosi_lvl_nxt;

  logic                      accept;
  logic                      busy;
  logic                      second;
  logic                      do_rise;
  logic                      done;
  logic                      rej;
  logic [spa_pkg::TickW-1:0] dur;
  logic [spa_pkg::TickW-1:0] tc_inc;
  logic [4:0]                bc_inc;
  spa_pkg::res_t             res;

  assign accept = in_valid && !in_stall;
  assign busy   = (phase_r != spa_pkg::PH_IDLE);
  assign second = phase_r inside {spa_pkg::PH_S2, spa_pkg::PH_H2, spa_pkg::PH_L2,
                                  spa_pkg::PH_G2};
  assign tc_inc = tick_cnt_r + spa_pkg::TickW'(1);
  assign bc_inc = bit_cnt_r + 5'd1;

  always_comb begin
    case (phase_r)
      spa_pkg::PH_S1, spa_pkg::PH_S2: dur = spa_pkg::dur_f(cs_setup_r);
      spa_pkg::PH_G1, spa_pkg::PH_G2: dur = spa_pkg::dur_f(frame_gap_r);
      default:                        dur = spa_pkg::dur_f(half_period_r);
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    bit_cnt_nxt     = bit_cnt_r;
    tick_cnt_nxt    = tick_cnt_r;
    tx_shift_nxt    = tx_shift_r;
    second_word_nxt = second_word_r;
    is_read_nxt     = is_read_r;
    rx_shift_nxt    = rx_shift_r;
    last_read_nxt   = last_read_r;
    mosi_lvl_nxt    = mosi_lvl_r;
    do_rise         = 1'b0;
    done            = 1'b0;
    rej             = 1'b0;

    case (in_opcode)
      spa_pkg::OP_TICK: begin
        if (busy) begin
          if (tc_inc < dur) begin
            tick_cnt_nxt = tc_inc;
          end else begin
            tick_cnt_nxt = '0;
            case (phase_r)
              spa_pkg::PH_S1: begin
                phase_nxt = spa_pkg::PH_H1;
                do_rise   = 1'b1;
              end
              spa_pkg::PH_S2: begin
                phase_nxt = spa_pkg::PH_H2;
                do_rise   = 1'b1;
              end
              spa_pkg::PH_H1: phase_nxt = spa_pkg::PH_L1;
              spa_pkg::PH_H2: phase_nxt = spa_pkg::PH_L2;
              spa_pkg::PH_L1, spa_pkg::PH_L2: begin
                if (int'(bc_inc) < spa_pkg::FrameBits) begin
                  bit_cnt_nxt = bc_inc;
                  phase_nxt   = second ? spa_pkg::PH_H2 : spa_pkg::PH_H1;
                  do_rise     = 1'b1;
                end else begin
                  bit_cnt_nxt  = '0;
                  mosi_lvl_nxt = 1'b0;
                  phase_nxt    = second ? spa_pkg::PH_G2 : spa_pkg::PH_G1;
                end
              end
              spa_pkg::PH_G1: begin
                tx_shift_nxt = second_word_r;
                phase_nxt    = spa_pkg::PH_S2;
              end
              spa_pkg::PH_G2: begin
                phase_nxt = spa_pkg::PH_IDLE;
                if (is_read_r) begin
                  last_read_nxt = rx_shift_r;
                end
                done = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      spa_pkg::OP_WRITE, spa_pkg::OP_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          is_read_nxt  = (in_opcode == spa_pkg::OP_READ);
          tx_shift_nxt = {8'h00, in_page};
          if (in_opcode == spa_pkg::OP_READ) begin
            second_word_nxt = {in_reg_addr, 1'b1, 8'h00};
          end else begin
            second_word_nxt = {in_reg_addr, 1'b0, in_wr_value};
          end
          rx_shift_nxt = '0;
          bit_cnt_nxt  = '0;
          tick_cnt_nxt = '0;
          mosi_lvl_nxt = 1'b0;
          phase_nxt    = spa_pkg::PH_S1;
        end
      end
      default: ;
    endcase

    // rising SCLK edge: read bits of the second frame sample MISO, others shift MOSI
    if (do_rise) begin
      if (is_read_r && second && int'(bit_cnt_nxt) >= spa_pkg::AddrBits) begin
        rx_shift_nxt = {rx_shift_r[6:0], in_miso};
      end else begin
        mosi_lvl_nxt = tx_shift_r[15];
        tx_shift_nxt = {tx_shift_r[14:0], 1'b0};
      end
    end
  end

  // result of this item, from the updated state
  always_comb begin
    res.busy_res  = (phase_nxt != spa_pkg::PH_IDLE);
    res.cs_n      = !res.busy_res || (phase_nxt inside {spa_pkg::PH_G1, spa_pkg::PH_G2});
    res.sclk      = phase_nxt inside {spa_pkg::PH_H1, spa_pkg::PH_H2};
    res.mosi      = res.busy_res && mosi_lvl_nxt;
    res.done_res  = done;
    res.rd_byte   = last_read_nxt;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= spa_pkg::PH_IDLE;
      bit_cnt_r     <= '0;
      tick_cnt_r    <= '0;
      tx_shift_r    <= '0;
      second_word_r <= '0;
      is_read_r     <= 1'b0;
      rx_shift_r    <= '0;
      last_read_r   <= '0;
      mosi_lvl_r    <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      tx_shift_r    <= tx_shift_nxt;
      second_word_r <= second_word_nxt;
      is_read_r     <= is_read_nxt;
      rx_shift_r    <= rx_shift_nxt;
      last_read_r   <= last_read_nxt;
      mosi_lvl_r    <= mosi_lvl_nxt;
    end
  end

  // ---------------- result register + skid ----------------
  logic          out_valid_r, skid_valid_r;
  spa_pkg::res_t out_r, skid_r;
  logic          out_free;

  assign in_stall = skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cs_n      = out_r.cs_n;
  assign out_sclk      = out_r.sclk;
  assign out_mosi      = out_r.mosi;
  assign out_busy_res  = out_r.busy_res;
  assign out_done_res  = out_r.done_res;
  assign out_rd_byte   = out_r.rd_byte;
  assign out_rejected  = out_r.rejected;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_done_ends_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res) |-> (!out_busy_res && out_cs_n && !out_sclk))
    else $error("completion reported while access still active");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !busy) |=> !((out_valid_r && out_r.rejected && !skid_valid_r &&
                             !$past(out_valid_r && out_stall))))
    else $error("request rejected while sequencer was idle");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_res) |-> (out_cs_n && !out_sclk && !out_mosi))
    else $error("SPI pins active while idle");

endmodule

`default_nettype wire
